/* sv/sacg_pkg.sv */
// Package: types and constants for the shake and click gesture detector.
`timescale 1ns / 1ps

package sacg_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned TimeBits   = 32;
  localparam int unsigned CountBits  = 5;
  localparam int unsigned ClickBits  = 2;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits    = 16;

  typedef enum logic [1:0] {
    SHAKE_NONE  = 2'd0,
    SHAKE_LEFT  = 2'd1,
    SHAKE_RIGHT = 2'd2
  } shake_e;

  typedef enum logic [1:0] {
    BTN_NONE         = 2'd0,
    BTN_LONG_PRESS   = 2'd1,
    BTN_DOUBLE_CLICK = 2'd2
  } button_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SHAKE_THRESHOLD = 3'd0,
    CFG_SHAKE_WINDOW    = 3'd1,
    CFG_SWINGS_TARGET   = 3'd2,
    CFG_HOLD            = 3'd3,
    CFG_DOUBLE_CLICK    = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] ShakeThresholdRst = 16'd8000;
  localparam logic [15:0] ShakeWindowRst    = 16'd1000;
  localparam logic [3:0]  SwingsTargetRst   = 4'd2;
  localparam logic [15:0] HoldRst           = 16'd3000;
  localparam logic [15:0] DoubleClickRst    = 16'd400;

  typedef struct packed {
    logic [15:0] swing_thresh;
    logic [15:0] swing_window;
    logic [3:0]  shake_swings_target;
    logic [15:0] hold_ms;
    logic [15:0] double_click_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] accel_x;
    logic                         button_down;
    logic [TimeBits-1:0]          now_ms;
  } in_item_t;

  typedef struct packed {
    shake_e  shake_gesture;
    button_e button_gesture;
  } out_item_t;

endpackage

/* sv/sacg_shake.sv */
// Shake path: swing detection, reversal counting and window state.
`timescale 1ns / 1ps

module sacg_shake (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  sacg_pkg::cfg_t                       cfg_i,
  input  logic signed [sacg_pkg::SampleBits-1:0] x_i,
  input  logic [sacg_pkg::TimeBits-1:0]        now_i,
  output sacg_pkg::shake_e                     gesture_o
);

  logic [sacg_pkg::SampleBits-1:0] prev_x_q, prev_x_d;
  logic [sacg_pkg::CountBits-1:0]  count_q, count_d;
  logic                            positive_q, positive_d;
  logic [sacg_pkg::TimeBits-1:0]   win_start_q, win_start_d;

  logic [sacg_pkg::SampleBits-1:0] delta;
  logic                            negative;
  logic                            positive;
  logic [sacg_pkg::SampleBits:0]   mag;
  logic [sacg_pkg::TimeBits-1:0]   elapsed;
  logic [sacg_pkg::CountBits-1:0]  count_inc;
  logic [sacg_pkg::CountBits-1:0]  needed;

  always_comb begin
    delta     = x_i - prev_x_q;
    negative  = delta[sacg_pkg::SampleBits-1];
    positive  = !negative && (delta != '0);
    mag       = negative ? ({1'b0, ~delta} + 1'b1) : {1'b0, delta};
    elapsed   = now_i - win_start_q;
    count_inc = count_q + 1'b1;
    needed    = {cfg_i.shake_swings_target, 1'b0};

    prev_x_d    = x_i;
    count_d     = count_q;
    positive_d  = positive_q;
    win_start_d = win_start_q;
    gesture_o   = sacg_pkg::SHAKE_NONE;

    if (mag >= {1'b0, cfg_i.swing_thresh}) begin
      if ((count_q == '0) ||
          (elapsed > sacg_pkg::TimeBits'(cfg_i.swing_window))) begin
        // open a new window at this swing
        count_d     = sacg_pkg::CountBits'(1);
        positive_d  = positive;
        win_start_d = now_i;
      end else if (positive != positive_q) begin
        positive_d = positive;
        count_d    = count_inc;
        if (count_inc >= needed) begin
          gesture_o = negative ? sacg_pkg::SHAKE_LEFT : sacg_pkg::SHAKE_RIGHT;
          count_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      count_q     <= '0;
      positive_q  <= 1'b0;
      win_start_q <= '0;
    end else if (step_i) begin
      prev_x_q    <= prev_x_d;
      count_q     <= count_d;
      positive_q  <= positive_d;
      win_start_q <= win_start_d;
    end
  end

endmodule

/* sv/sacg_button.sv */
// Button path: long press and double click detection.
`timescale 1ns / 1ps

module sacg_button (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  sacg_pkg::cfg_t                cfg_i,
  input  logic                          pressed_i,
  input  logic [sacg_pkg::TimeBits-1:0] now_i,
  output sacg_pkg::button_e             gesture_o
);

  logic                           held_q, held_d;
  logic [sacg_pkg::TimeBits-1:0]  press_q, press_d;
  logic [sacg_pkg::TimeBits-1:0]  last_q, last_d;
  logic [sacg_pkg::ClickBits-1:0] clicks_q, clicks_d;
  logic [sacg_pkg::TimeBits-1:0]  cwin_q, cwin_d;

  logic                          long_press;
  logic [sacg_pkg::TimeBits-1:0] hold_time;
  logic [sacg_pkg::TimeBits-1:0] since_cwin;
  logic [sacg_pkg::TimeBits-1:0] since_last;
  logic [sacg_pkg::TimeBits-1:0] dclick;

  always_comb begin
    hold_time  = now_i - press_q;
    since_cwin = now_i - cwin_q;
    dclick     = sacg_pkg::TimeBits'(cfg_i.double_click_ms);

    held_d     = held_q;
    press_d    = press_q;
    last_d     = last_q;
    clicks_d   = clicks_q;
    cwin_d     = cwin_q;
    long_press = 1'b0;
    gesture_o  = sacg_pkg::BTN_NONE;

    if (pressed_i && !held_q) begin
      held_d  = 1'b1;
      press_d = now_i;
    end else if (!pressed_i && held_q) begin
      held_d = 1'b0;
      if (hold_time >= sacg_pkg::TimeBits'(cfg_i.hold_ms)) begin
        clicks_d   = '0;
        long_press = 1'b1;
      end else begin
        if (since_cwin > dclick) begin
          clicks_d = sacg_pkg::ClickBits'(1);
          cwin_d   = now_i;
        end else begin
          clicks_d = clicks_q + 1'b1;
        end
        last_d = now_i;
      end
    end

    since_last = now_i - last_d;

    if (long_press) begin
      gesture_o = sacg_pkg::BTN_LONG_PRESS;
    end else begin
      // drop a lone click once its window has passed
      if (!held_d && (clicks_d == sacg_pkg::ClickBits'(1)) && (since_last > dclick)) begin
        clicks_d = '0;
      end
      if (clicks_d >= sacg_pkg::ClickBits'(2)) begin
        clicks_d  = '0;
        gesture_o = sacg_pkg::BTN_DOUBLE_CLICK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= 1'b0;
      press_q  <= '0;
      last_q   <= '0;
      clicks_q <= '0;
      cwin_q   <= '0;
    end else if (step_i) begin
      held_q   <= held_d;
      press_q  <= press_d;
      last_q   <= last_d;
      clicks_q <= clicks_d;
      cwin_q   <= cwin_d;
    end
  end

endmodule

/* sv/shake_and_click_gesture_detector_top.sv */
// Top level: handshake, configuration registers and the two gesture paths.
`timescale 1ns / 1ps
// Flow: an accepted item goes into the input register, which feeds the paths,
//   and the result register then holds the result item.
// Throughput: one item per cycle; the input stalls only while the input
//   register is full and the result register is held by a stalled output.
// Reset: asynchronous, active low; clears all gesture state and loads the
//   configuration defaults. No clearing pass follows reset.

module shake_and_click_gesture_detector_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input item channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sacg_pkg::in_item_t                  in_data_i,
  // result item channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sacg_pkg::out_item_t                 out_data_o,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sacg_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [sacg_pkg::CfgBits-1:0]        cfg_data_i
);

  // Configuration registers: always ready, unknown indexes drop the write.
  sacg_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.swing_thresh        <= sacg_pkg::ShakeThresholdRst;
      cfg_q.swing_window        <= sacg_pkg::ShakeWindowRst;
      cfg_q.shake_swings_target <= sacg_pkg::SwingsTargetRst;
      cfg_q.hold_ms             <= sacg_pkg::HoldRst;
      cfg_q.double_click_ms     <= sacg_pkg::DoubleClickRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sacg_pkg::CFG_SHAKE_THRESHOLD: cfg_q.swing_thresh        <= cfg_data_i;
        sacg_pkg::CFG_SHAKE_WINDOW:    cfg_q.swing_window        <= cfg_data_i;
        sacg_pkg::CFG_SWINGS_TARGET:   cfg_q.shake_swings_target <= cfg_data_i[3:0];
        sacg_pkg::CFG_HOLD:            cfg_q.hold_ms             <= cfg_data_i;
        sacg_pkg::CFG_DOUBLE_CLICK:    cfg_q.double_click_ms     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: holds one accepted item until the paths evaluate it.
  logic                in_valid_q;
  sacg_pkg::in_item_t  in_q;
  logic                in_fire;
  // Result register: holds the finished item until the output takes it.
  logic                out_valid_q;
  sacg_pkg::out_item_t out_q;
  // Advance the input item into the result register and step the state.
  logic                advance;

  sacg_pkg::shake_e    shake_res;
  sacg_pkg::button_e   button_res;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
  end

  sacg_shake u_shake (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .cfg_i     (cfg_q),
    .x_i       (in_q.accel_x),
    .now_i     (in_q.now_ms),
    .gesture_o (shake_res)
  );

  sacg_button u_button (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .cfg_i     (cfg_q),
    .pressed_i (in_q.button_down),
    .now_i     (in_q.now_ms),
    .gesture_o (button_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.shake_gesture  <= shake_res;
      out_q.button_gesture <= button_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An empty input register never stalls the input.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  // Every advance leaves a result waiting in the next cycle.
  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced item produced no result");

  // A stalled result is never overwritten by an advancing item.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !advance)
    else $error("result register overwritten while stalled");

  // An accepted item is held in the input register in the next cycle.
  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_valid_q)
    else $error("accepted item lost from input register");

endmodule

/* bench/shake_and_click_gesture_detector_top_tb.sv */
// Testbench: shake and click gesture detector, predicted and checked item by item.
`timescale 1ns / 1ps

module shake_and_click_gesture_detector_top_tb;

  // Receiver stall behaviors, switched at random intervals.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  // DUT connections; every input starts at a known value.
  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  sacg_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  sacg_pkg::out_item_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [sacg_pkg::CfgIdxBits-1:0] cfg_index = '0;
  logic [sacg_pkg::CfgBits-1:0]    cfg_data  = '0;

  // Predictor copy of the configuration registers, loaded with the reset values.
  logic [15:0] thr_cfg  = sacg_pkg::ShakeThresholdRst;
  logic [15:0] win_cfg  = sacg_pkg::ShakeWindowRst;
  logic [3:0]  tgt_cfg  = sacg_pkg::SwingsTargetRst;
  logic [15:0] hold_cfg = sacg_pkg::HoldRst;
  logic [15:0] dc_cfg   = sacg_pkg::DoubleClickRst;

  // Predictor copy of the gesture state; everything clears on reset.
  logic [15:0]                    last_x          = '0;
  logic [sacg_pkg::CountBits-1:0] swing_cnt       = '0;
  logic                           swing_up        = 1'b0;
  logic [31:0]                    shake_win_start = '0;
  logic                           btn_held        = 1'b0;
  logic [31:0]                    press_t0        = '0;
  logic [31:0]                    release_t       = '0;
  logic [sacg_pkg::ClickBits-1:0] clicks          = '0;
  logic [31:0]                    click_win_start = '0;

  // Results predicted for accepted items, oldest first.
  sacg_pkg::out_item_t expected_gestures[$];

  // Stimulus state: sensor clock, shake waveform and button script.
  logic [31:0] tick_ms     = '0;
  logic        wave_up     = 1'b0;
  logic        btn_level   = 1'b0;
  longint      btn_left_ms = 0;
  int          burst_left  = 0;

  // Receiver stall pattern state.
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;

  // Tallies for the summary and the verdict.
  int ticks_sent       = 0;
  int results_seen     = 0;
  int mismatches       = 0;
  int settings_applied = 0;
  int shakes_due       = 0;
  int long_presses_due = 0;
  int double_clicks_due = 0;
  sacg_pkg::out_item_t wanted;

  shake_and_click_gesture_detector_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk = ~clk;

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #2_000_000;
    $display("timeout: %0d items sent, %0d results seen", ticks_sent, results_seen);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Shake path: wrapping sample difference, swing detection and reversal count.
  function automatic sacg_pkg::shake_e shake_step(input logic [15:0] x,
                                                  input logic [31:0] now);
    logic [15:0]      delta;
    logic [15:0]      mag;
    logic             neg;
    logic             pos;
    sacg_pkg::shake_e res;
    res   = sacg_pkg::SHAKE_NONE;
    delta = x - last_x;
    neg   = delta[15];
    // The most negative difference negates to itself, giving a magnitude of 2^15.
    mag    = neg ? (~delta + 16'd1) : delta;
    last_x = x;
    if (mag < thr_cfg) return sacg_pkg::SHAKE_NONE;
    // A zero difference that still counts as a swing is taken as leftward.
    pos = !neg && (delta != 16'd0);
    // No swing counted yet or the window ran out: open a new window, report nothing.
    if (swing_cnt == '0 || (now - shake_win_start) > {16'd0, win_cfg}) begin
      swing_cnt       = sacg_pkg::CountBits'(1);
      swing_up        = pos;
      shake_win_start = now;
      return sacg_pkg::SHAKE_NONE;
    end
    if (pos != swing_up) begin
      swing_cnt = swing_cnt + 1'b1;
      swing_up  = pos;
      // A target of zero needs no swings, so any reversal reports.
      if (swing_cnt >= {tgt_cfg, 1'b0}) begin
        res       = neg ? sacg_pkg::SHAKE_LEFT : sacg_pkg::SHAKE_RIGHT;
        swing_cnt = '0;
      end
    end
    return res;
  endfunction

  // Button path: long press on release, two close releases make a double click.
  function automatic sacg_pkg::button_e button_step(input logic pressed,
                                                    input logic [31:0] now);
    if (pressed && !btn_held) begin
      btn_held = 1'b1;
      press_t0 = now;
    end else if (!pressed && btn_held) begin
      btn_held = 1'b0;
      // A long press drops any pending click but leaves the click timing alone.
      if ((now - press_t0) >= {16'd0, hold_cfg}) begin
        clicks = '0;
        return sacg_pkg::BTN_LONG_PRESS;
      end
      if ((now - click_win_start) > {16'd0, dc_cfg}) begin
        clicks          = sacg_pkg::ClickBits'(1);
        click_win_start = now;
      end else begin
        clicks = clicks + 1'b1;
      end
      release_t = now;
    end
    // Drop a lone click once the window since the last release has passed.
    if (!btn_held && clicks == 2'd1 && (now - release_t) > {16'd0, dc_cfg}) clicks = '0;
    if (clicks >= 2'd2) begin
      clicks = '0;
      return sacg_pkg::BTN_DOUBLE_CLICK;
    end
    return sacg_pkg::BTN_NONE;
  endfunction

  function automatic sacg_pkg::out_item_t predict_gestures(input sacg_pkg::in_item_t item);
    sacg_pkg::out_item_t res;
    res.shake_gesture  = shake_step(item.accel_x, item.now_ms);
    res.button_gesture = button_step(item.button_down, item.now_ms);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one item. The sender runs in bursts; between bursts valid drops for a
  // random gap. Inside a burst valid stays high from item to item.
  task automatic send_tick(input sacg_pkg::in_item_t item);
    sacg_pkg::out_item_t res;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    // Hold the item until an edge sees it with stall low.
    do @(posedge clk); while (in_stall);
    res = predict_gestures(item);
    expected_gestures.push_back(res);
    if (res.shake_gesture != sacg_pkg::SHAKE_NONE) shakes_due++;
    if (res.button_gesture == sacg_pkg::BTN_LONG_PRESS) long_presses_due++;
    if (res.button_gesture == sacg_pkg::BTN_DOUBLE_CLICK) double_clicks_due++;
    ticks_sent++;
    burst_left--;
  endtask

  // Advance the sensor clock by dt (wrapping) and send one sensor tick.
  task automatic tick(input logic signed [15:0] x, input logic btn, input logic [31:0] dt);
    sacg_pkg::in_item_t item;
    tick_ms          = tick_ms + dt;
    item.accel_x     = x;
    item.button_down = btn;
    item.now_ms      = tick_ms;
    send_tick(item);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic settle_outputs();
    in_valid <= 1'b0;
    while (expected_gestures.size() != 0) @(posedge clk);
  endtask

  // Write one register and mirror it in the predictor. Valid is left high so
  // that back-to-back writes need no second assignment in one step.
  task automatic write_register(input logic [sacg_pkg::CfgIdxBits-1:0] idx,
                                input logic [sacg_pkg::CfgBits-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    unique case (idx)
      sacg_pkg::CFG_SHAKE_THRESHOLD: thr_cfg  = val;
      sacg_pkg::CFG_SHAKE_WINDOW:    win_cfg  = val;
      sacg_pkg::CFG_SWINGS_TARGET:   tgt_cfg  = val[3:0];
      sacg_pkg::CFG_HOLD:            hold_cfg = val;
      sacg_pkg::CFG_DOUBLE_CLICK:    dc_cfg   = val;
      default: ;
    endcase
  endtask

  // Program all five registers while the block is idle, plus one write to an
  // index past the list, which the block must ignore.
  task automatic set_registers(input logic [15:0] thr, input logic [15:0] win,
                               input logic [15:0] tgt_raw, input logic [15:0] hold,
                               input logic [15:0] dc);
    settle_outputs();
    write_register(sacg_pkg::CFG_SHAKE_THRESHOLD, thr);
    write_register(sacg_pkg::CFG_SHAKE_WINDOW, win);
    write_register(sacg_pkg::CFG_SWINGS_TARGET, tgt_raw);
    write_register(sacg_pkg::CFG_HOLD, hold);
    write_register(sacg_pkg::CFG_DOUBLE_CLICK, dc);
    write_register(sacg_pkg::CfgIdxBits'($urandom_range(
                     int'(sacg_pkg::CFG_DOUBLE_CLICK) + 1,
                     (1 << sacg_pkg::CfgIdxBits) - 1)),
                   sacg_pkg::CfgBits'($urandom));
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Random sensor traffic. Most ticks follow a shake waveform whose swings sit
  // around the current threshold, and the button follows a script of press and
  // release lengths near the hold and click windows; the rest is raw noise.
  task automatic run_sensor_traffic(input int n, input int step_unit);
    int                 amp;
    int                 thr;
    logic [31:0]        dt;
    logic signed [15:0] x;
    logic               btn;
    for (int i = 0; i < n; i++) begin
      dt = ($urandom_range(0, 63) == 0) ? $urandom : $urandom_range(0, step_unit);
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 4) != 0) wave_up = !wave_up;
        thr = int'(thr_cfg);
        amp = thr / 2 + int'($urandom_range(0, thr / 4 + 2)) - thr / 8;
        if (amp < 0) amp = 0;
        if (amp > 32767) amp = 32767;
        x = wave_up ? 16'(amp) : 16'(-amp);
      end else begin
        x = 16'($urandom);
      end
      if (longint'(dt) >= btn_left_ms) begin
        btn_level = !btn_level;
        if (btn_level) begin
          // Either a short click or a press straddling the long-press time.
          if ($urandom_range(0, 1) == 0) begin
            btn_left_ms = $urandom_range(0, int'(dc_cfg));
          end else begin
            btn_left_ms = (int'(hold_cfg) > 100 ? int'(hold_cfg) - 100 : 0)
                          + $urandom_range(0, 200);
          end
        end else begin
          btn_left_ms = $urandom_range(0, 2 * int'(dc_cfg) + 10);
        end
      end else begin
        btn_left_ms -= longint'(dt);
      end
      // Occasional glitch on the button level.
      btn = btn_level ^ ($urandom_range(0, 29) == 0);
      tick(x, btn, dt);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  // Stall pattern: each stretch picks a behavior, from none at all to heavy.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    unique case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
      STALL_PERIODIC: out_stall <= ((stall_left % 8) < 3);
      default:        out_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_gestures.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result %0d: shake %0d button %0d", results_seen,
                   out_data.shake_gesture, out_data.button_gesture);
        mismatches++;
      end else begin
        wanted = expected_gestures.pop_front();
        if (out_data.shake_gesture !== wanted.shake_gesture ||
            out_data.button_gesture !== wanted.button_gesture) begin
          if (mismatches < 10)
            $display("result %0d: expected shake %0d button %0d, got shake %0d button %0d",
                     results_seen, wanted.shake_gesture, wanted.button_gesture,
                     out_data.shake_gesture, out_data.button_gesture);
          mismatches++;
        end
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: sample extremes, most negative difference, a rightward
  // shake, a long press across the timestamp wrap, a double click in the same
  // tick as a leftward shake, and a lone click that gets dropped.
  task automatic test_reset_defaults();
    tick_ms = 32'hFFFF_F800;
    tick(16'sd0, 1'b0, 0);           // zero difference, below threshold
    tick(16'sh8000, 1'b1, 40);       // most negative difference; press
    tick(16'sh7FFF, 1'b1, 40);       // wraps to a difference of -1
    tick(16'sd0, 1'b1, 40);          // leftward, no reversal
    tick(16'sd20000, 1'b1, 40);
    tick(16'sd0, 1'b1, 40);
    tick(16'sd20000, 1'b1, 40);      // fourth swing: shake ending rightward
    tick(16'sd20000, 1'b1, 3000);    // hold across the timestamp wrap
    tick(-16'sd20000, 1'b0, 10);     // release: long press
    tick(16'sd20000, 1'b1, 30);
    tick(16'sd20000, 1'b0, 30);      // first click opens the window
    tick(16'sd28000, 1'b1, 30);
    tick(16'sd0, 1'b0, 30);          // double click and leftward shake together
    tick(16'sd0, 1'b1, 30);
    tick(16'sd0, 1'b0, 30);          // lone click pending
    tick(16'sd0, 1'b0, 500);         // window passed with the button up
  endtask

  // Degenerate settings: zero threshold, zero windows, a target masked to
  // zero and zero hold; then a threshold of 2^15 with the widest windows.
  task automatic test_degenerate_settings();
    set_registers(16'd0, 16'd0, 16'hFFF0, 16'd0, 16'd0);
    tick(16'sd0, 1'b0, 0);           // zero difference counts as a leftward swing
    tick(16'sd0, 1'b1, 0);
    tick(16'sd1, 1'b0, 0);           // reversal reports; release is a long press
    tick(16'sd1, 1'b0, 1);
    set_registers(16'd32768, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
    tick(16'sh8000, 1'b1, 5);        // only the most negative difference swings
    tick(16'sd0, 1'b0, 5);
    tick(16'sh8000, 1'b1, 5);
    tick(16'sd0, 1'b0, 5);           // second release within the wide window
  endtask

  // Random traffic under fixed extreme and typical settings.
  task automatic test_extreme_settings();
    set_registers(16'd8000, 16'd1000, 16'd2, 16'd3000, 16'd400);
    run_sensor_traffic(200, 120);
    set_registers(16'd0, 16'hFFFF, 16'd15, 16'd0, 16'hFFFF);
    run_sensor_traffic(150, 50);
    set_registers(16'd32768, 16'd0, 16'd1, 16'hFFFF, 16'd0);
    run_sensor_traffic(150, 3);
    set_registers(16'hFFFF, 16'd300, 16'd3, 16'd500, 16'd200);
    run_sensor_traffic(100, 60);
    set_registers(16'd1000, 16'd2000, 16'hABC0, 16'd1000, 16'd250);
    run_sensor_traffic(150, 80);
  endtask

  // Random traffic under random settings, upper register bits included.
  task automatic test_random_settings();
    for (int p = 0; p < 3; p++) begin
      set_registers(16'($urandom_range(0, 20000)), 16'($urandom_range(0, 4000)),
                    16'($urandom), 16'($urandom_range(0, 5000)),
                    16'($urandom_range(0, 1000)));
      run_sensor_traffic(100, $urandom_range(1, 400));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_degenerate_settings();
    test_extreme_settings();
    test_random_settings();

    // Wait for the last results, then keep watching to catch any stray output.
    settle_outputs();
    repeat (4) @(posedge clk);

    $display("Ran %0d sensor ticks under %0d register settings plus the reset defaults,",
             ticks_sent, settings_applied);
    $display("checking %0d results: %0d shakes, %0d long presses, %0d double clicks",
             results_seen, shakes_due, long_presses_due, double_clicks_due);
    if (mismatches == 0 && expected_gestures.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
